FILE: rtl/sfd_pkg.sv
// Shared types, constants and the soft-clip table for the stereo feedback delay.
// No dependencies; every other file of the block imports this package.
package sfd_pkg;

  localparam int SB               = 24;
  localparam int DELAY_DEPTH      = 65536;
  localparam int ADDR_BITS        = $clog2(DELAY_DEPTH);
  localparam int CLIP_TABLE_DEPTH = 256;
  localparam int IDX_BITS         = $clog2(CLIP_TABLE_DEPTH);
  localparam int POS_W            = 16 + IDX_BITS;
  localparam int CEIL_W           = 23;
  localparam int MA_W             = SB + 2;
  localparam int MB_W             = 17;
  localparam int ACC_W            = MA_W + MB_W + 1;

  localparam logic [2:0] REG_ENABLE   = 3'd0;
  localparam logic [2:0] REG_DELAY    = 3'd1;
  localparam logic [2:0] REG_FB_GAIN  = 3'd2;
  localparam logic [2:0] REG_LP_COEFF = 3'd3;
  localparam logic [2:0] REG_WET      = 3'd4;
  localparam logic [2:0] REG_DRY      = 3'd5;
  localparam logic [2:0] REG_CEIL     = 3'd6;

  typedef struct packed {
    logic signed [SB-1:0] left_in;
    logic signed [SB-1:0] right_in;
  } in_frame_t;

  typedef struct packed {
    logic signed [SB-1:0] left_out;
    logic signed [SB-1:0] right_out;
  } out_frame_t;

  typedef struct packed {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
  } pair_t;

  typedef struct packed {
    logic                   en;
    logic                   acc;
    logic signed [MA_W-1:0] a;
    logic signed [MB_W-1:0] b;
  } mac_req_t;

  typedef struct packed {
    logic              start;
    logic [SB-1:0]     dividend;
    logic [CEIL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic                 rd_en;
    logic [ADDR_BITS-1:0] delay;
    logic                 wr_en;
    pair_t                wdata;
  } dl_req_t;

  typedef logic [15:0] clip_table_t [0:CLIP_TABLE_DEPTH];

  // shift-and-subtract quotient of two non-negative values, for the table build
  function automatic longint udiv(longint num, longint den);
    longint q;
    longint rem;
    q   = 0;
    rem = 0;
    for (int i = 62; i >= 0; i--) begin
      rem = (rem <<< 1) | ((num >>> i) & 64'sd1);
      q   = q <<< 1;
      if (rem >= den) begin
        rem = rem - den;
        q   = q | 64'sd1;
      end
    end
    return q;
  endfunction

  // tanh(u) for u in [0,4] in Q0.16, built from a Q24 exponential series
  function automatic clip_table_t build_clip_table();
    clip_table_t tbl;
    longint      h;
    longint      term;
    longint      r;
    longint      e;
    longint      num;
    longint      den;
    h    = (64'sd8 <<< 24) / CLIP_TABLE_DEPTH;
    term = 64'sd1 <<< 24;
    r    = 64'sd1 <<< 24;
    e    = 64'sd1 <<< 24;
    for (int n = 1; n <= 12; n++) begin
      term = udiv((term * h) >>> 24, longint'(n));
      r    = r + term;
    end
    tbl[0] = 16'd0;
    for (int k = 1; k <= CLIP_TABLE_DEPTH; k++) begin
      e      = (e * r + (64'sd1 <<< 23)) >>> 24;
      num    = (e - (64'sd1 <<< 24)) * 64'sd65536;
      den    = e + (64'sd1 <<< 24);
      tbl[k] = 16'(udiv(num + den / 2, den));
    end
    return tbl;
  endfunction

  localparam clip_table_t CLIP_TABLE = build_clip_table();

  function automatic logic signed [SB-1:0] sat_sample(input logic signed [31:0] v);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    hi = (32'sd1 <<< (SB - 1)) - 32'sd1;
    lo = -hi - 32'sd1;
    if (v > hi) begin
      return hi[SB-1:0];
    end else if (v < lo) begin
      return lo[SB-1:0];
    end
    return v[SB-1:0];
  endfunction

endpackage

FILE: rtl/sfd_mac.sv
// Shared multiply-accumulate unit: one signed multiplier and an accumulator.
// Depends on sfd_pkg.
module sfd_mac import sfd_pkg::*; (
  input  logic                    clk_i,
  input  mac_req_t                req_i,
  output logic signed [ACC_W-1:0] acc_o
);

  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] prod;

  assign prod  = ACC_W'(req_i.a) * ACC_W'(req_i.b);
  assign acc_o = acc_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      acc_q <= (req_i.acc ? acc_q : '0) + prod;
    end
  end

endmodule

FILE: rtl/sfd_div.sv
// Radix-2 restoring divider for the soft-clip table position, one bit a cycle.
// Depends on sfd_pkg; the caller guarantees dividend < 4 * divisor.
module sfd_div import sfd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [CEIL_W-1:0]     rem_q;
  logic [SB-1:0]         low_q;
  logic [POS_W-1:0]      quo_q;
  logic [$clog2(POS_W+1)-1:0] cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic [CEIL_W:0]       trial;
  logic                  fits;

  assign trial = {rem_q, low_q[SB-1]};
  assign fits  = trial >= {1'b0, req_i.divisor};

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !req_i.start && (cnt_q == 1);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= ($clog2(POS_W+1))'(POS_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // dividend is |x| << (POS_W - 2): seed the remainder with |x| >> 2
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= CEIL_W'(req_i.dividend >> 2);
      low_q <= {req_i.dividend[1:0], {(SB-2){1'b0}}};
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? CEIL_W'(trial - {1'b0, req_i.divisor}) : trial[CEIL_W-1:0];
      low_q <= {low_q[SB-2:0], 1'b0};
      quo_q <= {quo_q[POS_W-2:0], fits};
    end
  end

endmodule

FILE: rtl/sfd_dline.sv
// Stereo delay memory with write pointer; unwritten entries read as zero.
// Depends on sfd_pkg.
module sfd_dline import sfd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  dl_req_t req_i,
  output pair_t   rdata_o
);

  pair_t                mem [DELAY_DEPTH];
  pair_t                mem_q;
  logic [ADDR_BITS-1:0] wp_q;
  logic                 wrapped_q;
  logic                 rvalid_q;
  logic [ADDR_BITS-1:0] rd_addr;

  assign rd_addr = wp_q - req_i.delay;
  assign rdata_o = rvalid_q ? mem_q : '0;

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      mem_q <= mem[rd_addr];
    end
    if (req_i.wr_en) begin
      mem[wp_q] <= req_i.wdata;
    end
  end

  // entries are written in address order, so below the pointer or after a wrap is valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      wrapped_q <= 1'b0;
      rvalid_q  <= 1'b0;
    end else begin
      if (req_i.rd_en) begin
        rvalid_q <= wrapped_q || (rd_addr < wp_q);
      end
      if (req_i.wr_en) begin
        wp_q <= wp_q + 1'b1;
        if (wp_q == {ADDR_BITS{1'b1}}) begin
          wrapped_q <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/stereo_feedback_delay_core.sv
// Stereo feedback delay top level: registers, sequencer, output register.
// Depends on sfd_pkg, sfd_mac, sfd_div and sfd_dline.
//
//  channel | signals                              | transfer
//  --------+--------------------------------------+-------------------------
//  input   | in_valid_i, in_ready_o, in_data_i    | valid && ready at clk
//  output  | out_valid_o, out_ready_i, out_data_o | valid && ready at clk
//  config  | cfg_we_i, cfg_index_i, cfg_wdata_i   | write enable at clk
//
// Enabled, a frame's two channels run through one shared multiplier in turn, and the
// 24-step table position divider, when it runs, is the longest step of a channel. Disabled,
// a frame skips the processing states and goes straight to the output register.
// The delay memory needs no clearing pass: a wrap flag marks unwritten entries as zero.
// A finished result waits in the output register while the next frame is taken.
module stereo_feedback_delay_core import sfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_frame_t   in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_frame_t  out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [22:0] cfg_wdata_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_LP_MUL, ST_LP_UPD, ST_FB_MUL, ST_FB_X, ST_DIV, ST_TAB,
    ST_INTERP, ST_CEIL_MUL, ST_CEIL_RES, ST_DRY_MUL, ST_WET_MUL, ST_OUT, ST_FINISH
  } state_e;

  logic              enable_q;
  logic [15:0]       delay_q;
  logic [15:0]       fb_gain_q;
  logic [15:0]       lp_coeff_q;
  logic [15:0]       wet_q;
  logic [15:0]       dry_q;
  logic [CEIL_W-1:0] ceil_q;
  logic [CEIL_W-1:0] ceil_eff;

  state_e               state_q;
  logic                 ch_q;
  logic signed [SB-1:0] in_q      [2];
  logic signed [SB-1:0] delayed_q [2];
  logic signed [SB-1:0] lp_q      [2];
  logic signed [SB-1:0] wr_q      [2];
  logic signed [SB-1:0] res_q     [2];
  logic                 neg_q;
  logic [15:0]          y_q;
  logic [15:0]          t0_q;
  logic                 out_valid_q;
  out_frame_t           out_q;

  mac_req_t                mac_req;
  logic signed [ACC_W-1:0] acc;
  div_req_t                div_req;
  div_rsp_t                div_rsp;
  dl_req_t                 dl_req;
  pair_t                   dl_rdata;

  logic                    in_xfer;
  logic signed [ACC_W-1:0] acc_r16;
  logic signed [ACC_W-1:0] acc_r15;
  logic signed [SB+1:0]    diff;
  logic signed [SB+1:0]    lp_sum;
  logic signed [SB+1:0]    x_val;
  logic signed [SB+1:0]    x_abs;
  logic [SB-1:0]           a_mag;
  logic [IDX_BITS-1:0]     idx;
  logic [15:0]             frac;
  logic [15:0]             t0;
  logic [15:0]             t1;
  logic [15:0]             tdiff;
  logic [CEIL_W-1:0]       mag;
  logic signed [SB+1:0]    fb_sum;
  logic signed [28:0]      out_val;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign ceil_eff    = (ceil_q == '0) ? CEIL_W'(1) : ceil_q;

  assign acc_r16 = acc + ACC_W'(32768);
  assign acc_r15 = acc + ACC_W'(16384);
  assign diff    = {{2{delayed_q[ch_q][SB-1]}}, delayed_q[ch_q]}
                 - {{2{lp_q[ch_q][SB-1]}}, lp_q[ch_q]};
  assign lp_sum  = {{2{lp_q[ch_q][SB-1]}}, lp_q[ch_q]} + acc_r16[41:16];
  assign x_val   = acc_r16[41:16];
  assign x_abs   = x_val[SB+1] ? -x_val : x_val;
  assign a_mag   = x_abs[SB-1:0];
  assign idx     = div_rsp.quotient[POS_W-1:16];
  assign frac    = div_rsp.quotient[15:0];
  assign t0      = CLIP_TABLE[(IDX_BITS+1)'(idx)];
  assign t1      = CLIP_TABLE[(IDX_BITS+1)'(idx) + 1'b1];
  assign tdiff   = (t1 > t0) ? t1 - t0 : 16'd0;
  assign mag     = acc_r16[CEIL_W+15:16];
  assign fb_sum  = {{2{in_q[ch_q][SB-1]}}, in_q[ch_q]}
                 + (neg_q ? -(SB+2)'(mag) : (SB+2)'(mag));
  assign out_val = acc_r15[43:15];

  always_comb begin
    mac_req     = '0;
    div_req     = '0;
    dl_req      = '0;
    div_req.dividend = a_mag;
    div_req.divisor  = ceil_eff;
    dl_req.delay     = delay_q;
    dl_req.wdata     = '{left: wr_q[0], right: wr_q[1]};
    dl_req.rd_en     = in_xfer && enable_q;
    unique case (state_q)
      ST_LP_MUL: begin
        mac_req = '{en: 1'b1, acc: 1'b0, a: diff, b: {1'b0, lp_coeff_q}};
      end
      ST_FB_MUL: begin
        mac_req = '{en: 1'b1, acc: 1'b0, a: MA_W'(lp_q[ch_q]), b: {1'b0, fb_gain_q}};
      end
      ST_FB_X: begin
        div_req.start = ({1'b0, a_mag} < {ceil_eff, 2'b00});
      end
      ST_TAB: begin
        mac_req = '{en: 1'b1, acc: 1'b0, a: MA_W'(tdiff), b: {1'b0, frac}};
      end
      ST_CEIL_MUL: begin
        mac_req = '{en: 1'b1, acc: 1'b0, a: MA_W'(ceil_eff), b: {1'b0, y_q}};
      end
      ST_DRY_MUL: begin
        mac_req = '{en: 1'b1, acc: 1'b0, a: MA_W'(in_q[ch_q]), b: {1'b0, dry_q}};
      end
      ST_WET_MUL: begin
        mac_req = '{en: 1'b1, acc: 1'b1, a: MA_W'(delayed_q[ch_q]), b: {1'b0, wet_q}};
      end
      ST_OUT: begin
        dl_req.wr_en = ch_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      delay_q    <= 16'd2880;
      fb_gain_q  <= 16'd0;
      lp_coeff_q <= 16'd32768;
      wet_q      <= 16'd23170;
      dry_q      <= 16'd23170;
      ceil_q     <= 23'd4194304;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ENABLE:   enable_q   <= cfg_wdata_i[0];
        REG_DELAY:    delay_q    <= cfg_wdata_i[15:0];
        REG_FB_GAIN:  fb_gain_q  <= cfg_wdata_i[15:0];
        REG_LP_COEFF: lp_coeff_q <= cfg_wdata_i[15:0];
        REG_WET:      wet_q      <= cfg_wdata_i[15:0];
        REG_DRY:      dry_q      <= cfg_wdata_i[15:0];
        REG_CEIL:     ceil_q     <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= 1'b0;
      out_valid_q <= 1'b0;
      lp_q[0]     <= '0;
      lp_q[1]     <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != ST_FINISH) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            in_q[0]  <= in_data_i.left_in;
            in_q[1]  <= in_data_i.right_in;
            res_q[0] <= in_data_i.left_in;
            res_q[1] <= in_data_i.right_in;
            ch_q     <= 1'b0;
            state_q  <= enable_q ? ST_READ : ST_FINISH;
          end
        end
        ST_READ: begin
          delayed_q[0] <= dl_rdata.left;
          delayed_q[1] <= dl_rdata.right;
          state_q      <= ST_LP_MUL;
        end
        ST_LP_MUL: state_q <= ST_LP_UPD;
        ST_LP_UPD: begin
          lp_q[ch_q] <= lp_sum[SB-1:0];
          state_q    <= ST_FB_MUL;
        end
        ST_FB_MUL: state_q <= ST_FB_X;
        ST_FB_X: begin
          neg_q <= x_val[SB+1];
          if (div_req.start) begin
            state_q <= ST_DIV;
          end else begin
            // at or beyond four times the ceiling: hold the last table entry
            y_q     <= CLIP_TABLE[CLIP_TABLE_DEPTH];
            state_q <= ST_CEIL_MUL;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            state_q <= ST_TAB;
          end
        end
        ST_TAB: begin
          t0_q    <= t0;
          state_q <= ST_INTERP;
        end
        ST_INTERP: begin
          y_q     <= t0_q + acc_r16[31:16];
          state_q <= ST_CEIL_MUL;
        end
        ST_CEIL_MUL: state_q <= ST_CEIL_RES;
        ST_CEIL_RES: begin
          wr_q[ch_q] <= sat_sample(32'(fb_sum));
          state_q    <= ST_DRY_MUL;
        end
        ST_DRY_MUL: state_q <= ST_WET_MUL;
        ST_WET_MUL: state_q <= ST_OUT;
        ST_OUT: begin
          res_q[ch_q] <= sat_sample(32'(out_val));
          if (ch_q) begin
            state_q <= ST_FINISH;
          end else begin
            ch_q    <= 1'b1;
            state_q <= ST_LP_MUL;
          end
        end
        ST_FINISH: begin
          // hold until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_q       <= '{left_out: res_q[0], right_out: res_q[1]};
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  sfd_mac u_mac (
    .clk_i (clk_i),
    .req_i (mac_req),
    .acc_o (acc)
  );

  sfd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  sfd_dline u_dline (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (dl_req),
    .rdata_o (dl_rdata)
  );

endmodule

FILE: rtl/sfd_checker.sv
// Port-level checks for the stereo feedback delay, bound to the top level.
// Depends on sfd_pkg and stereo_feedback_delay_core.
module sfd_checker import sfd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input in_frame_t   in_data_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input out_frame_t  out_data_o,
  input logic        cfg_we_i,
  input logic [2:0]  cfg_index_i,
  input logic [22:0] cfg_wdata_i
);

  logic      en_q;
  logic [1:0] cnt_q;
  in_frame_t cap_q;
  logic      in_xfer;
  logic      out_xfer;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (cfg_we_i && cfg_index_i == REG_ENABLE) begin
        en_q <= cfg_wdata_i[0];
      end
      cnt_q <= cnt_q + {1'b0, in_xfer} - {1'b0, out_xfer};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cap_q <= in_data_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("ready still high after an input transfer");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != 2'd0)
    else $error("result without an outstanding frame");

  a_max_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("more than two frames outstanding");

  a_passthrough: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !en_q && cnt_q == 2'd1 |->
      out_data_o.left_out == cap_q.left_in && out_data_o.right_out == cap_q.right_in)
    else $error("disabled result differs from input");

endmodule

bind stereo_feedback_delay_core sfd_checker u_sfd_checker (.*);
